// ===== rtl/lslf_pkg.sv =====
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared types and constants of the least-squares line fit block: register
// indexes, result status codes, product selector and controller interface.
// ----------------------------------------------------------------------------
package lslf_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int WINDOW_W    = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = WINDOW_W;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd8;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWAP_AXES    = 1'b1;

  // Q16.16 result format
  localparam int RESULT_W  = 32;
  localparam int FRAC_BITS = 16;
  // one extra quotient bit flags an overflow of the 32-bit magnitude
  localparam int QUOT_W    = RESULT_W + 1;
  localparam int DIV_CNT_W = 6;

  localparam logic [RESULT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [RESULT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_ZERO_DEN = 2'd2
  } status_e;

  localparam int STATUS_W = 2;

  // Products of the fit, in the order the sequencer runs them
  typedef enum logic [2:0] {
    PROD_C_SXX  = 3'd0,
    PROD_SX_SX  = 3'd1,
    PROD_C_SXY  = 3'd2,
    PROD_SX_SY  = 3'd3,
    PROD_SXX_SY = 3'd4,
    PROD_SXY_SX = 3'd5
  } prod_e;

  typedef struct packed {
    logic    accum;
    logic    mul_load;
    logic    clear_acc;
    logic    mul_step;
    logic    latch_den;
    logic    div_load;
    logic    div_step;
    logic    store_slope;
    logic    store_intercept;
    logic    load_out;
    prod_e   prod;
    status_e status;
  } lslf_cmd_t;

  typedef struct packed {
    logic too_few;
    logic mul_done;
    logic den_zero;
    logic div_last;
  } lslf_stat_t;

endpackage

// ===== rtl/lslf_datapath.sv =====
// ----------------------------------------------------------------------------
// lslf_datapath
// Configuration registers, point accumulators, bit-serial signed
// multiply-accumulate, radix-2 restoring divider and result registers.
// ----------------------------------------------------------------------------
module lslf_datapath #(
  parameter int MAX_POINTS  = lslf_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = lslf_pkg::COORD_WIDTH_DEF,
  parameter int S_TDATA_W   = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lslf_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [lslf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [S_TDATA_W-1:0]                s_tdata_i,
  input  lslf_pkg::lslf_cmd_t                 cmd_i,
  output lslf_pkg::lslf_stat_t                stat_o,
  output logic [2*lslf_pkg::RESULT_W-1:0]     m_tdata_o,
  output logic [lslf_pkg::STATUS_W-1:0]       m_tuser_o
);

  localparam int PTS_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_WIDTH + PTS_W;
  localparam int SQ_W   = 2 * COORD_WIDTH + PTS_W;
  localparam int ACC_W  = SQ_W + SUM_W + 1;
  localparam int DIV_W  = ACC_W + lslf_pkg::QUOT_W;
  localparam int CMP_W  = (PTS_W > lslf_pkg::WINDOW_W) ? PTS_W : lslf_pkg::WINDOW_W;
  localparam int RW     = lslf_pkg::RESULT_W;

  // configuration
  logic [lslf_pkg::WINDOW_W-1:0] window_q;
  logic                          swap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= lslf_pkg::WINDOW_RESET;
      swap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lslf_pkg::REG_WINDOW_COUNT: window_q <= cfg_data_i;
        lslf_pkg::REG_SWAP_AXES:    swap_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective window, clamped to [2, MAX_POINTS]
  logic [CMP_W-1:0] wc_ext;
  logic [CMP_W-1:0] n_cmp;
  logic [PTS_W-1:0] n_eff;

  always_comb begin
    wc_ext = CMP_W'(window_q);
    if (wc_ext < CMP_W'(2)) begin
      n_cmp = CMP_W'(2);
    end else if (wc_ext > CMP_W'(MAX_POINTS)) begin
      n_cmp = CMP_W'(MAX_POINTS);
    end else begin
      n_cmp = wc_ext;
    end
  end
  assign n_eff = PTS_W'(n_cmp);

  // accumulators
  logic        [PTS_W-1:0]         points_q;
  logic signed [SUM_W-1:0]         sum_first_q, sum_second_q;
  logic signed [SQ_W-1:0]          sum_sq_q, sum_cross_q;
  logic signed [COORD_WIDTH-1:0]   coord_a, coord_b;
  logic signed [2*COORD_WIDTH-1:0] prod_aa, prod_ab;
  logic                            take;

  assign coord_a = swap_q ? s_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH]
                          : s_tdata_i[COORD_WIDTH-1:0];
  assign coord_b = swap_q ? s_tdata_i[COORD_WIDTH-1:0]
                          : s_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];
  assign prod_aa = coord_a * coord_a;
  assign prod_ab = coord_a * coord_b;
  assign take    = points_q < n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q     <= '0;
      sum_first_q  <= '0;
      sum_second_q <= '0;
      sum_sq_q     <= '0;
      sum_cross_q  <= '0;
    end else if (cmd_i.load_out) begin
      points_q     <= '0;
      sum_first_q  <= '0;
      sum_second_q <= '0;
      sum_sq_q     <= '0;
      sum_cross_q  <= '0;
    end else if (cmd_i.accum && take) begin
      points_q     <= points_q + PTS_W'(1);
      sum_first_q  <= sum_first_q + SUM_W'(coord_a);
      sum_second_q <= sum_second_q + SUM_W'(coord_b);
      sum_sq_q     <= sum_sq_q + SQ_W'(prod_aa);
      sum_cross_q  <= sum_cross_q + SQ_W'(prod_ab);
    end
  end

  // operand selection for the shared multiplier
  logic signed [SQ_W-1:0]  op_a;
  logic signed [SUM_W-1:0] op_b;
  logic                    op_sub;
  logic [SQ_W-1:0]         mag_a;
  logic [SUM_W-1:0]        mag_b;

  always_comb begin
    unique case (cmd_i.prod)
      lslf_pkg::PROD_C_SXX: begin
        op_a = sum_sq_q;              op_b = SUM_W'(points_q);   op_sub = 1'b0;
      end
      lslf_pkg::PROD_SX_SX: begin
        op_a = SQ_W'(sum_first_q);    op_b = sum_first_q;        op_sub = 1'b1;
      end
      lslf_pkg::PROD_C_SXY: begin
        op_a = sum_cross_q;           op_b = SUM_W'(points_q);   op_sub = 1'b0;
      end
      lslf_pkg::PROD_SX_SY: begin
        op_a = SQ_W'(sum_first_q);    op_b = sum_second_q;       op_sub = 1'b1;
      end
      lslf_pkg::PROD_SXX_SY: begin
        op_a = sum_sq_q;              op_b = sum_second_q;       op_sub = 1'b0;
      end
      lslf_pkg::PROD_SXY_SX: begin
        op_a = sum_cross_q;           op_b = sum_first_q;        op_sub = 1'b1;
      end
      default: begin
        op_a = '0;                    op_b = '0;                 op_sub = 1'b0;
      end
    endcase
    mag_a = op_a[SQ_W-1]  ? (~op_a + SQ_W'(1))  : op_a;
    mag_b = op_b[SUM_W-1] ? (~op_b + SUM_W'(1)) : op_b;
  end

  // bit-serial multiply-accumulate: one multiplier bit per cycle
  logic [ACC_W-1:0]        mul_a_q;
  logic [SUM_W-1:0]        mul_b_q;
  logic                    mul_neg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]        den_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mul_a_q   <= ACC_W'(mag_a);
      mul_b_q   <= mag_b;
      mul_neg_q <= op_a[SQ_W-1] ^ op_b[SUM_W-1] ^ op_sub;
      if (cmd_i.clear_acc) begin
        acc_q <= '0;
      end
    end else if (cmd_i.mul_step) begin
      if (mul_b_q[0]) begin
        acc_q <= mul_neg_q ? (acc_q - mul_a_q) : (acc_q + mul_a_q);
      end
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
    end
    if (cmd_i.latch_den) begin
      den_q <= acc_q;
    end
  end

  // restoring divider: |num| * 2^16 / den, rounded half away from zero
  logic [DIV_W-1:0]              rem_q, dvs_q;
  logic [lslf_pkg::QUOT_W-1:0]   quot_q;
  logic [lslf_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic                          div_neg_q;
  logic [ACC_W-1:0]              mag_num;
  logic                          rem_ge;

  assign mag_num = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
  assign rem_ge  = rem_q >= dvs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      div_neg_q <= acc_q[ACC_W-1];
      rem_q     <= DIV_W'({mag_num, {(lslf_pkg::FRAC_BITS + 1){1'b0}}}) + DIV_W'(den_q);
      dvs_q     <= DIV_W'({den_q, {lslf_pkg::QUOT_W{1'b0}}});
      quot_q    <= '0;
      div_cnt_q <= lslf_pkg::DIV_CNT_W'(lslf_pkg::QUOT_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      quot_q    <= {quot_q[lslf_pkg::QUOT_W-2:0], rem_ge};
      dvs_q     <= dvs_q >> 1;
      div_cnt_q <= div_cnt_q - lslf_pkg::DIV_CNT_W'(1);
    end
  end

  // saturate and apply sign
  logic          sat_hit;
  logic [RW-1:0] quot_mag, quot_fix;

  always_comb begin
    sat_hit  = div_neg_q ? (quot_q > {1'b0, lslf_pkg::SAT_NEG})
                         : (quot_q > {1'b0, lslf_pkg::SAT_POS});
    quot_mag = sat_hit ? (div_neg_q ? lslf_pkg::SAT_NEG : lslf_pkg::SAT_POS)
                       : quot_q[RW-1:0];
    quot_fix = div_neg_q ? (~quot_mag + RW'(1)) : quot_mag;
  end

  logic [RW-1:0] slope_q, intercept_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_slope) begin
      slope_q <= quot_fix;
    end
    if (cmd_i.store_intercept) begin
      intercept_q <= quot_fix;
    end
    if (cmd_i.load_out) begin
      m_tuser_o <= cmd_i.status;
      if (cmd_i.status == lslf_pkg::STATUS_OK) begin
        m_tdata_o <= {intercept_q, slope_q};
      end else begin
        m_tdata_o <= '0;
      end
    end
  end

  assign stat_o.too_few  = take;
  assign stat_o.mul_done = (mul_b_q == '0);
  assign stat_o.den_zero = (den_q == '0);
  assign stat_o.div_last = (div_cnt_q == '0);

endmodule

// ===== rtl/lslf_ctrl.sv =====
// ----------------------------------------------------------------------------
// lslf_ctrl
// Sequencer of the fit: takes points, then steps the shared multiplier and
// divider through the six products and two quotients, and hands off results.
// ----------------------------------------------------------------------------
module lslf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tlast_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  lslf_pkg::lslf_stat_t stat_i,
  output lslf_pkg::lslf_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIT,
    S_MUL_LOAD,
    S_MUL_RUN,
    S_CHECK,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_DIV_STORE,
    S_OUT
  } state_e;

  state_e            state_q;
  lslf_pkg::prod_e   prod_q;
  lslf_pkg::status_e status_q;
  logic              out_valid_q;
  logic              accept;
  logic              out_free;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o                 = '0;
    cmd_o.prod            = prod_q;
    cmd_o.status          = status_q;
    cmd_o.accum           = accept;
    cmd_o.mul_load        = (state_q == S_MUL_LOAD);
    cmd_o.clear_acc       = (prod_q == lslf_pkg::PROD_C_SXX) ||
                            (prod_q == lslf_pkg::PROD_C_SXY) ||
                            (prod_q == lslf_pkg::PROD_SXX_SY);
    cmd_o.mul_step        = (state_q == S_MUL_RUN) && !stat_i.mul_done;
    cmd_o.latch_den       = (state_q == S_MUL_RUN) && stat_i.mul_done &&
                            (prod_q == lslf_pkg::PROD_SX_SX);
    cmd_o.div_load        = (state_q == S_DIV_LOAD);
    cmd_o.div_step        = (state_q == S_DIV_RUN);
    cmd_o.store_slope     = (state_q == S_DIV_STORE) && (prod_q == lslf_pkg::PROD_SX_SY);
    cmd_o.store_intercept = (state_q == S_DIV_STORE) && (prod_q == lslf_pkg::PROD_SXY_SX);
    cmd_o.load_out        = (state_q == S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prod_q      <= lslf_pkg::PROD_C_SXX;
      status_q    <= lslf_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      // a handoff in the same cycle refills the slot below
      if (out_valid_q && m_tready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && s_tlast_i) begin
            state_q <= S_FIT;
          end
        end
        S_FIT: begin
          if (stat_i.too_few) begin
            status_q <= lslf_pkg::STATUS_SHORT;
            state_q  <= S_OUT;
          end else begin
            status_q <= lslf_pkg::STATUS_OK;
            prod_q   <= lslf_pkg::PROD_C_SXX;
            state_q  <= S_MUL_LOAD;
          end
        end
        S_MUL_LOAD: state_q <= S_MUL_RUN;
        S_MUL_RUN: begin
          if (stat_i.mul_done) begin
            unique case (prod_q)
              lslf_pkg::PROD_C_SXX: begin
                prod_q  <= lslf_pkg::PROD_SX_SX;
                state_q <= S_MUL_LOAD;
              end
              lslf_pkg::PROD_SX_SX: state_q <= S_CHECK;
              lslf_pkg::PROD_C_SXY: begin
                prod_q  <= lslf_pkg::PROD_SX_SY;
                state_q <= S_MUL_LOAD;
              end
              lslf_pkg::PROD_SXX_SY: begin
                prod_q  <= lslf_pkg::PROD_SXY_SX;
                state_q <= S_MUL_LOAD;
              end
              default: state_q <= S_DIV_LOAD;
            endcase
          end
        end
        S_CHECK: begin
          if (stat_i.den_zero) begin
            status_q <= lslf_pkg::STATUS_ZERO_DEN;
            state_q  <= S_OUT;
          end else begin
            prod_q  <= lslf_pkg::PROD_C_SXY;
            state_q <= S_MUL_LOAD;
          end
        end
        S_DIV_LOAD: state_q <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (stat_i.div_last) begin
            state_q <= S_DIV_STORE;
          end
        end
        S_DIV_STORE: begin
          if (prod_q == lslf_pkg::PROD_SX_SY) begin
            prod_q  <= lslf_pkg::PROD_SXX_SY;
            state_q <= S_MUL_LOAD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_starts_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_tlast_i) |=> (state_q == S_FIT))
    else $error("final point did not start the fit");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_tready_i))
    else $error("result overwrote a pending transaction");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside the handoff state");

  a_div_entered_by_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_RUN) |->
      ($past(state_q) == S_DIV_LOAD || $past(state_q) == S_DIV_RUN))
    else $error("divider ran without a load");
`endif

endmodule

// ===== rtl/least_squares_line_fit.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Least-squares straight-line fit over the leading points of each set,
// giving slope and intercept in saturated signed Q16.16.
// ----------------------------------------------------------------------------
// Points stream in one per transaction; tlast marks the final point of a set.
// The first window_count points (clamped to 2..MAX_POINTS) are summed as
// sum x, sum y, sum x^2 and sum xy; later points of the set are taken and
// dropped. A point without tlast leaves the block ready for the next point.
// The final point starts the fit, during which the input is held off: six
// products run through one shared bit-serial signed multiplier (one
// multiplier bit per cycle, after a load step) and two quotients through one
// radix-2 restoring divider (each with load and store steps). A short set or
// a zero denominator ends the fit before the divider runs. The result waits
// in an output register, so the next set's points are taken while it is
// still pending. tuser carries the status: 0 ok, 1 too few points (fields
// zero), 2 zero denominator (fields zero). Results are rounded to nearest,
// ties away from zero. swap_axes exchanges x and y of each point as it
// arrives. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
module least_squares_line_fit #(
  parameter int MAX_POINTS  = lslf_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = lslf_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [lslf_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [lslf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // point stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: x_coord, y_coord, zero fill to whole bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  input  logic                                s_axis_tlast,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: slope, intercept
  output logic [2*lslf_pkg::RESULT_W-1:0]     m_axis_tdata,
  // tuser: status
  output logic [lslf_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int S_TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

  lslf_pkg::lslf_cmd_t  cmd;
  lslf_pkg::lslf_stat_t stat;

  // sequencer: handshakes and step commands
  lslf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // accumulators, multiplier, divider and result registers
  lslf_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH),
    .S_TDATA_W   (S_TDATA_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule
